// File: rtl/core/qblp_pkg.sv
package qblp_pkg;

	localparam int unsigned LIMIT_W = 64;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned OUT_DATA_W = 72;

	localparam logic [LIMIT_W-1:0] DEFAULT_LIMIT_RST = 64'd65536;
	localparam logic [LIMIT_W-1:0] MAX_LIMIT_RST     = 64'd1048576;

	localparam logic [BYTE_W-1:0] CH_QUESTION = 8'h3F;
	localparam logic [BYTE_W-1:0] CH_AMP      = 8'h26;
	localparam logic [BYTE_W-1:0] CH_EQUAL    = 8'h3D;
	localparam logic [BYTE_W-1:0] CH_ZERO     = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE     = 8'h39;

	localparam logic [2:0] KEY_LEN = 3'd5;

	typedef enum logic [1:0] {
		REG_DEFAULT_LIMIT = 2'd0,
		REG_MAX_LIMIT     = 2'd1,
		REG_CLAMP_ENABLE  = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_SEEK  = 3'd0,
		PH_KEY   = 3'd1,
		PH_VALUE = 3'd2,
		PH_SKIP  = 3'd3,
		PH_DONE  = 3'd4
	} phase_t;

	// scan state captured on the last byte of a target
	typedef struct packed {
		logic               nonempty;
		logic               invalid;
		logic [LIMIT_W-1:0] acc;
	} snap_t;

	// letters of the key "bytes"
	function automatic logic [BYTE_W-1:0] key_char(input logic [2:0] pos);
		logic [BYTE_W-1:0] c;
		c = '0;
		case (pos)
			3'd0: c = 8'h62;
			3'd1: c = 8'h79;
			3'd2: c = 8'h74;
			3'd3: c = 8'h65;
			3'd4: c = 8'h73;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

// File: rtl/core/qblp_scan.sv
module qblp_scan (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [qblp_pkg::BYTE_W-1:0]   in_byte,
	input  logic                          in_last,
	output logic                          snap_valid,
	input  logic                          snap_ready,
	output qblp_pkg::snap_t               snap
);

	logic                         vld_s1;
	logic [qblp_pkg::BYTE_W-1:0]  byte_s1;
	logic                         last_s1;

	qblp_pkg::phase_t             phase_q, phase_d;
	logic [2:0]                   pos_q, pos_d;
	logic                         mis_q, mis_d;
	logic [qblp_pkg::LIMIT_W-1:0] acc_q, acc_d;
	logic                         ne_q, ne_d;
	logic                         inv_q, inv_d;

	logic                         snap_vld_q;
	qblp_pkg::snap_t              snap_s2;

	logic                         s2_free;
	logic                         consume;
	logic                         key_hit;
	logic                         is_digit;
	logic [qblp_pkg::LIMIT_W+3:0] prod;

	assign s2_free  = !snap_vld_q || snap_ready;
	assign consume  = vld_s1 && (!last_s1 || s2_free);
	assign in_ready = !vld_s1 || consume;

	assign key_hit  = !mis_q && (pos_q == qblp_pkg::KEY_LEN);
	assign is_digit = (byte_s1 >= qblp_pkg::CH_ZERO) && (byte_s1 <= qblp_pkg::CH_NINE);
	// acc * 10 + digit, carried wide to spot a 64-bit overflow
	assign prod = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1)
		+ {{(qblp_pkg::LIMIT_W){1'b0}}, byte_s1[3:0]};

	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		mis_d   = mis_q;
		acc_d   = acc_q;
		ne_d    = ne_q;
		inv_d   = inv_q;
		unique case (phase_q)
			qblp_pkg::PH_SEEK: begin
				if (byte_s1 == qblp_pkg::CH_QUESTION) begin
					phase_d = qblp_pkg::PH_KEY;
					pos_d   = 3'd0;
					mis_d   = 1'b0;
				end
			end
			qblp_pkg::PH_KEY: begin
				if (byte_s1 == qblp_pkg::CH_EQUAL) begin
					phase_d = key_hit ? qblp_pkg::PH_VALUE : qblp_pkg::PH_SKIP;
				end else if (byte_s1 == qblp_pkg::CH_AMP) begin
					if (key_hit) begin
						// key without '=': value stays empty
						phase_d = qblp_pkg::PH_DONE;
					end else begin
						pos_d = 3'd0;
						mis_d = 1'b0;
					end
				end else if (pos_q < qblp_pkg::KEY_LEN
						&& byte_s1 == qblp_pkg::key_char(pos_q)) begin
					pos_d = pos_q + 3'd1;
				end else begin
					mis_d = 1'b1;
				end
			end
			qblp_pkg::PH_VALUE: begin
				if (byte_s1 == qblp_pkg::CH_AMP) begin
					phase_d = qblp_pkg::PH_DONE;
				end else begin
					ne_d = 1'b1;
					if (!is_digit || (|prod[qblp_pkg::LIMIT_W+3:qblp_pkg::LIMIT_W])) begin
						inv_d = 1'b1;
					end else begin
						acc_d = prod[qblp_pkg::LIMIT_W-1:0];
					end
				end
			end
			qblp_pkg::PH_SKIP: begin
				if (byte_s1 == qblp_pkg::CH_AMP) begin
					phase_d = qblp_pkg::PH_KEY;
					pos_d   = 3'd0;
					mis_d   = 1'b0;
				end
			end
			qblp_pkg::PH_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= qblp_pkg::PH_SEEK;
			pos_q   <= 3'd0;
			mis_q   <= 1'b0;
			acc_q   <= '0;
			ne_q    <= 1'b0;
			inv_q   <= 1'b0;
		end else if (consume) begin
			if (last_s1) begin
				// target ends: start over for the next one
				phase_q <= qblp_pkg::PH_SEEK;
				pos_q   <= 3'd0;
				mis_q   <= 1'b0;
				acc_q   <= '0;
				ne_q    <= 1'b0;
				inv_q   <= 1'b0;
			end else begin
				phase_q <= phase_d;
				pos_q   <= pos_d;
				mis_q   <= mis_d;
				acc_q   <= acc_d;
				ne_q    <= ne_d;
				inv_q   <= inv_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_vld_q <= 1'b0;
		end else if (consume && last_s1) begin
			snap_vld_q <= 1'b1;
		end else if (snap_ready) begin
			snap_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && last_s1) begin
			snap_s2.nonempty <= ne_d;
			snap_s2.invalid  <= inv_d;
			snap_s2.acc      <= acc_d;
		end
	end

	assign snap_valid = snap_vld_q;
	assign snap       = snap_s2;

endmodule

// File: rtl/core/qblp_result.sv
module qblp_result (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             snap_valid,
	output logic                             snap_ready,
	input  qblp_pkg::snap_t                  snap,
	input  logic [qblp_pkg::LIMIT_W-1:0]     default_limit,
	input  logic [qblp_pkg::LIMIT_W-1:0]     max_limit,
	input  logic                             clamp_enable,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [qblp_pkg::OUT_DATA_W-1:0]  out_data
);

	logic                         vld_q;
	logic                         status_q;
	logic [qblp_pkg::LIMIT_W-1:0] limit_q;
	logic                         out_en;
	logic                         status_d;
	logic [qblp_pkg::LIMIT_W-1:0] limit_d;

	assign out_en     = !vld_q || out_ready;
	assign snap_ready = out_en;

	always_comb begin
		status_d = 1'b0;
		limit_d  = snap.acc;
		if (!snap.nonempty) begin
			limit_d = default_limit;
		end else if (snap.invalid) begin
			status_d = 1'b1;
			limit_d  = '0;
		end else if (clamp_enable && snap.acc > max_limit) begin
			limit_d = max_limit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (out_en) begin
			vld_q <= snap_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en && snap_valid) begin
			status_q <= status_d;
			limit_q  <= limit_d;
		end
	end

	assign out_valid = vld_q;
	assign out_data  = {{(qblp_pkg::OUT_DATA_W - qblp_pkg::LIMIT_W - 1){1'b0}},
		limit_q, status_q};

endmodule

// File: rtl/core/query_byte_limit_parser.sv
// Byte-limit parser for an HTTP request target. Feed the target one byte per
// word on s_tdata, with s_tlast on its final byte; unless stalled, one word
// per cycle is taken. The first "bytes=" item of the query decides the
// limit: a missing or empty value yields default_limit, a non-digit or a
// value past 2^64-1 yields status 1 with limit 0, otherwise the decimal
// value (clamped to max_limit when clamp_enable is set). One result word
// leaves on m_tdata per target, after its last byte passes the snapshot and
// result registers; the per-byte step is a combinational multiply-by-ten
// accumulate in the scan stage. Bytes keep flowing while a result waits on
// m_tready; only a second final byte stalls. Write registers through
// cfg_we/cfg_index/cfg_data while no target is in flight.
module query_byte_limit_parser (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [qblp_pkg::BYTE_W-1:0]      s_tdata,   // [7:0] target_byte
	input  logic                             s_tlast,   // last_byte
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [qblp_pkg::OUT_DATA_W-1:0]  m_tdata,   // [0] status, [64:1] byte_limit
	input  logic                             cfg_we,
	input  logic [1:0]                       cfg_index,
	input  logic [qblp_pkg::LIMIT_W-1:0]     cfg_data
);

	logic [qblp_pkg::LIMIT_W-1:0] default_limit_q;
	logic [qblp_pkg::LIMIT_W-1:0] max_limit_q;
	logic                         clamp_enable_q;

	logic                         snap_valid;
	logic                         snap_ready;
	qblp_pkg::snap_t              snap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_limit_q <= qblp_pkg::DEFAULT_LIMIT_RST;
			max_limit_q     <= qblp_pkg::MAX_LIMIT_RST;
			clamp_enable_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				qblp_pkg::REG_DEFAULT_LIMIT: default_limit_q <= cfg_data;
				qblp_pkg::REG_MAX_LIMIT:     max_limit_q     <= cfg_data;
				qblp_pkg::REG_CLAMP_ENABLE:  clamp_enable_q  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	qblp_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_byte    (s_tdata),
		.in_last    (s_tlast),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.snap       (snap)
	);

	qblp_result u_result (
		.clk           (clk),
		.arst_n        (arst_n),
		.snap_valid    (snap_valid),
		.snap_ready    (snap_ready),
		.snap          (snap),
		.default_limit (default_limit_q),
		.max_limit     (max_limit_q),
		.clamp_enable  (clamp_enable_q),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_data      (m_tdata)
	);

`ifndef SYNTHESIS
	// a malformed value always reports a zero limit
	a_malformed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[64:1] == 64'd0)
		else $error("malformed result carries a nonzero limit");

	// input stalls only when a result is stuck at the output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output back-pressure");

	// a result leaves only after being taken
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(m_tvalid) |-> $past(m_tready))
		else $error("result dropped before it was taken");

	// nothing but zero padding above the limit field
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[71:65] == 7'd0)
		else $error("padding bits of the result word are not zero");
`endif

endmodule

// File: bench/testbench.sv
module testbench;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_BYTES    = 245;
	localparam logic [qblp_pkg::LIMIT_W-1:0] ALL_ONES = '1;
	localparam logic [39:0] KEY_WORD = "bytes";

	typedef struct packed {
		logic [qblp_pkg::BYTE_W-1:0] data;
		logic                        last;
	} target_word_t;

	typedef struct {
		logic                         status;
		logic [qblp_pkg::LIMIT_W-1:0] limit;
	} limit_result_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [qblp_pkg::BYTE_W-1:0]     s_tdata = '0;    // [7:0] target_byte
	logic                            s_tlast = 1'b0;  // last_byte
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [qblp_pkg::OUT_DATA_W-1:0] m_tdata;         // [0] status, [64:1] byte_limit
	logic                            cfg_we = 1'b0;
	logic [1:0]                      cfg_index = '0;
	logic [qblp_pkg::LIMIT_W-1:0]    cfg_data = '0;

	target_word_t  pending_words[$];
	limit_result_t limits_due[$];
	logic [qblp_pkg::BYTE_W-1:0] frame[$];

	// parser model state and register copy
	qblp_pkg::phase_t             scan_ph = qblp_pkg::PH_SEEK;
	logic [2:0]                   match_len = '0;
	logic                         key_bad = 1'b0;
	logic [qblp_pkg::LIMIT_W-1:0] value_acc = '0;
	logic                         value_seen = 1'b0;
	logic                         value_bad = 1'b0;
	logic [qblp_pkg::LIMIT_W-1:0] dflt_limit = qblp_pkg::DEFAULT_LIMIT_RST;
	logic [qblp_pkg::LIMIT_W-1:0] ceil_limit = qblp_pkg::MAX_LIMIT_RST;
	logic                         clamp_on = 1'b0;

	int   mismatches = 0;
	int   phase_bytes = 0;
	int   src_hold = 0;
	int   sink_hold = 0;
	int   idle_cycles = 0;
	logic quiet_tail = 1'b0;
	target_word_t next_word;

	query_byte_limit_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// source side: one word per handshake, random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (src_hold > 0) begin
				src_hold--;
				s_tvalid <= 1'b0;
			end else if (pending_words.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				src_hold = $urandom_range(1, 17) - 1;
				s_tvalid <= 1'b0;
			end else begin
				next_word = pending_words.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= next_word.data;
				s_tlast  <= next_word.last;
			end
		end
	end

	// sink side backpressure
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (sink_hold > 0) begin
			sink_hold--;
			m_tready <= 1'b0;
		end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
			sink_hold = $urandom_range(1, 17) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : limit_check
		logic [qblp_pkg::BYTE_W-1:0]  c;
		logic [qblp_pkg::LIMIT_W-1:0] d;
		limit_result_t                want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (limits_due.size() == 0) begin
					$error("unexpected result word: status %0d byte_limit %0d",
						m_tdata[0], m_tdata[64:1]);
					mismatches++;
				end else begin
					want = limits_due.pop_front();
					if (m_tdata[0] !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, m_tdata[0]);
						mismatches++;
					end
					if (m_tdata[64:1] !== want.limit) begin
						$error("byte_limit: expected %0d, got %0d", want.limit, m_tdata[64:1]);
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				c = s_tdata;
				case (scan_ph)
					qblp_pkg::PH_SEEK: begin
						if (c == qblp_pkg::CH_QUESTION) begin
							scan_ph = qblp_pkg::PH_KEY;
							match_len = '0;
							key_bad = 1'b0;
						end
					end
					qblp_pkg::PH_KEY: begin
						if (c == qblp_pkg::CH_EQUAL) begin
							if (!key_bad && match_len == qblp_pkg::KEY_LEN)
								scan_ph = qblp_pkg::PH_VALUE;
							else
								scan_ph = qblp_pkg::PH_SKIP;
						end else if (c == qblp_pkg::CH_AMP) begin
							// a bare "bytes" key ends the search with an empty value
							if (!key_bad && match_len == qblp_pkg::KEY_LEN) begin
								scan_ph = qblp_pkg::PH_DONE;
							end else begin
								match_len = '0;
								key_bad = 1'b0;
							end
						end else if (match_len < qblp_pkg::KEY_LEN
								&& c == KEY_WORD[39 - 8 * int'(match_len) -: 8]) begin
							match_len++;
						end else begin
							key_bad = 1'b1;
						end
					end
					qblp_pkg::PH_VALUE: begin
						if (c == qblp_pkg::CH_AMP) begin
							scan_ph = qblp_pkg::PH_DONE;
						end else begin
							value_seen = 1'b1;
							if (c >= qblp_pkg::CH_ZERO && c <= qblp_pkg::CH_NINE) begin
								d = {56'd0, c - qblp_pkg::CH_ZERO};
								if (value_acc > (ALL_ONES - d) / 10)
									value_bad = 1'b1;
								else
									value_acc = value_acc * 10 + d;
							end else begin
								value_bad = 1'b1;
							end
						end
					end
					qblp_pkg::PH_SKIP: begin
						if (c == qblp_pkg::CH_AMP) begin
							scan_ph = qblp_pkg::PH_KEY;
							match_len = '0;
							key_bad = 1'b0;
						end
					end
					default: ;
				endcase
				if (s_tlast) begin
					if (!value_seen) begin
						want.status = 1'b0;
						want.limit = dflt_limit;
					end else if (value_bad) begin
						want.status = 1'b1;
						want.limit = '0;
					end else begin
						want.status = 1'b0;
						want.limit = value_acc;
						if (clamp_on && want.limit > ceil_limit)
							want.limit = ceil_limit;
					end
					limits_due = {limits_due, want};
					scan_ph = qblp_pkg::PH_SEEK;
					match_len = '0;
					key_bad = 1'b0;
					value_acc = '0;
					value_seen = 1'b0;
					value_bad = 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	task automatic add_byte(input logic [qblp_pkg::BYTE_W-1:0] b);
		frame = {frame, b};
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	task automatic add_digits(input int n);
		repeat (n) add_byte(qblp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
	endtask

	task automatic add_any_byte(input int n);
		repeat (n) add_byte(8'($urandom_range(0, 255)));
	endtask

	// hand the frame to the driver, last flag on its final byte
	task automatic flush_frame();
		target_word_t w;
		if (frame.size() == 0)
			add_any_byte(1);
		for (int i = 0; i < frame.size(); i++) begin
			w.data = frame[i];
			w.last = (i == frame.size() - 1);
			pending_words = {pending_words, w};
		end
		phase_bytes += frame.size();
		frame.delete();
	endtask

	task automatic add_value();
		logic [qblp_pkg::BYTE_W-1:0] b;
		case ($urandom_range(0, 9))
			0: ;
			1: add_digits($urandom_range(1, 20));
			2: add_text($sformatf("%0d", {$urandom, $urandom}));
			3: begin
				// right at the 64-bit ceiling
				add_text("1844674407370955161");
				add_digits(1);
				if ($urandom_range(0, 3) == 0)
					add_digits(1);
			end
			4: add_text($sformatf("%0d", ceil_limit + 64'($urandom_range(0, 4)) - 64'd2));
			5: begin
				add_digits($urandom_range(0, 5));
				do b = 8'($urandom_range(0, 255));
				while ((b >= qblp_pkg::CH_ZERO && b <= qblp_pkg::CH_NINE)
					|| b == qblp_pkg::CH_AMP);
				add_byte(b);
				add_digits($urandom_range(0, 5));
			end
			6: begin
				add_digits(0);
				repeat ($urandom_range(1, 25)) add_byte(qblp_pkg::CH_ZERO);
				add_digits($urandom_range(0, 3));
			end
			7: add_text($sformatf("%0d", $urandom_range(0, 2000000)));
			8: begin
				add_digits($urandom_range(1, 4));
				add_byte(qblp_pkg::CH_EQUAL);
				add_digits($urandom_range(0, 4));
			end
			default: begin
				add_text($sformatf("%0d", {$urandom, $urandom}));
				add_digits($urandom_range(1, 3));
			end
		endcase
	endtask

	task automatic add_key();
		string letters;
		letters = "bytesxB?9";
		case ($urandom_range(0, 9))
			0, 1, 2, 3: add_text("bytes");
			4: add_text("byte");
			5: add_text("bytess");
			6: add_text("Bytes");
			7: ;
			8: repeat ($urandom_range(1, 6)) add_byte(letters[$urandom_range(0, 8)]);
			default: add_text($urandom_range(0, 1) ? "bytes?" : "xbytes");
		endcase
	endtask

	task automatic add_target();
		string mix;
		int    n;
		mix = "?&=bytes019x";
		case ($urandom_range(0, 9))
			0: add_any_byte($urandom_range(1, 30));
			1: repeat ($urandom_range(1, 30)) add_byte(mix[$urandom_range(0, 11)]);
			default: begin
				if ($urandom_range(0, 2) != 0) begin
					add_text("/");
					repeat ($urandom_range(0, 6)) add_byte(8'("a" + $urandom_range(0, 25)));
				end
				if ($urandom_range(0, 9) != 0)
					add_byte(qblp_pkg::CH_QUESTION);
				n = $urandom_range(0, 4);
				for (int i = 0; i < n; i++) begin
					if (i > 0)
						add_byte(qblp_pkg::CH_AMP);
					add_key();
					if ($urandom_range(0, 6) != 0) begin
						add_byte(qblp_pkg::CH_EQUAL);
						add_value();
					end
				end
				if ($urandom_range(0, 7) == 0)
					add_byte(qblp_pkg::CH_AMP);
			end
		endcase
		flush_frame();
	endtask

	task automatic fill_phase();
		phase_bytes = 0;
		while (phase_bytes < PHASE_BYTES)
			add_target();
	endtask

	task automatic wait_drained();
		while (pending_words.size() != 0 || s_tvalid || limits_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_reg(input qblp_pkg::reg_idx_t idx,
			input logic [qblp_pkg::LIMIT_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			qblp_pkg::REG_DEFAULT_LIMIT: dflt_limit = val;
			qblp_pkg::REG_MAX_LIMIT:     ceil_limit = val;
			qblp_pkg::REG_CLAMP_ENABLE:  clamp_on = val[0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// let the parser settle, then change its registers
	task automatic next_setting(input logic [qblp_pkg::LIMIT_W-1:0] dflt,
			input logic [qblp_pkg::LIMIT_W-1:0] ceil, input logic clamp);
		logic [qblp_pkg::LIMIT_W-1:0] clamp_word;
		clamp_word = {$urandom, $urandom};
		clamp_word[0] = clamp;
		wait_drained();
		repeat (8) @(posedge clk);
		set_reg(qblp_pkg::REG_DEFAULT_LIMIT, dflt);
		set_reg(qblp_pkg::REG_MAX_LIMIT, ceil);
		set_reg(qblp_pkg::REG_CLAMP_ENABLE, clamp_word);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset register values; short targets first
		add_byte(8'h00);
		flush_frame();
		add_byte(8'hFF);
		flush_frame();
		add_byte(qblp_pkg::CH_QUESTION);
		flush_frame();
		add_text("?bytes=");
		flush_frame();
		add_text("?bytes=0");
		flush_frame();
		add_text("?=&");
		flush_frame();
		fill_phase();

		next_setting('0, '0, 1'b1);
		fill_phase();
		next_setting(ALL_ONES, ALL_ONES, 1'b1);
		fill_phase();
		next_setting({$urandom, $urandom}, 64'($urandom_range(0, 100000)), 1'b1);
		fill_phase();
		next_setting({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
		fill_phase();
		next_setting({$urandom, $urandom}, 64'($urandom_range(0, 1000000000)), 1'b1);
		quiet_tail = 1'b1;
		fill_phase();

		wait_drained();
		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
